// ----- rtl/met_pkg.sv -----
// Shared constants, payload types and controller states of the escape-time unit.
`timescale 1ns / 1ps
`default_nettype none

package met_pkg;

    // Fixed point format: signed Q4.60 in 64 bits.
    localparam int Q_W     = 64;
    localparam int FRAC_W  = 60;
    localparam int ZOOM_W  = 6;
    localparam int PIX_W   = 9;
    localparam int CNT_W   = 8;

    // The multiplier consumes one digit of its second operand per cycle.
    localparam int DIGIT_W    = 16;
    localparam int NUM_DIGITS = Q_W / DIGIT_W;

    // Bits 127..60 of a full product, that is the product truncated to Q4.60.
    localparam int HI_W = 2 * Q_W - FRAC_W;

    localparam int ITER_LIMIT_DEF = 256;
    localparam int TILE_EDGE_DEF  = 512;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_REAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_IMAG = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZOOM_LEVEL  = 2'd2;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_col;
        logic [PIX_W-1:0] pixel_row;
    } t_pixel;

    typedef struct packed {
        logic [CNT_W-1:0] escape_count;
        logic             no_escape;
    } t_result;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] reg_index;
        logic [Q_W-1:0]       write_data;
    } t_cfg;

    typedef struct packed {
        logic           start;
        logic [Q_W-1:0] op_a;
        logic [Q_W-1:0] op_b;
    } t_mul_req;

    typedef struct packed {
        logic            done;
        logic [HI_W-1:0] prod_hi;
        logic            frac_nz;
    } t_mul_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_COORD,
        S_ITER,
        S_SQR_R,
        S_SQR_I,
        S_TEST,
        S_CROSS,
        S_UPDATE,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/met_chan_if.sv -----
// Valid/ready channel interface that carries one item of a given payload type.
`timescale 1ns / 1ps
`default_nettype none

interface met_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/met_digit_mul.sv -----
// Digit-serial unsigned 64 by 64 multiplier that returns the product truncated to Q4.60.
`timescale 1ns / 1ps
`default_nettype none

module met_digit_mul (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire met_pkg::t_mul_req i_req,
    output met_pkg::t_mul_rsp      o_rsp
);

    localparam int QW    = met_pkg::Q_W;
    localparam int DW    = met_pkg::DIGIT_W;
    localparam int ACC_W = QW + DW;
    localparam int CW    = $clog2(met_pkg::NUM_DIGITS + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [QW-1:0] r_a, n_a;
    logic [QW-1:0] r_b, n_b;
    logic [QW-1:0] r_acc, n_acc;
    logic [QW-1:0] r_lo, n_lo;

    logic [ACC_W-1:0] w_pp;
    logic [ACC_W-1:0] w_sum;

    // One partial product per cycle; the low digit of the running sum is final.
    assign w_pp  = ACC_W'(r_a) * ACC_W'(r_b[DW-1:0]);
    assign w_sum = w_pp + ACC_W'(r_acc);

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        n_lo   = r_lo;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(met_pkg::NUM_DIGITS);
            n_a    = i_req.op_a;
            n_b    = i_req.op_b;
            n_acc  = '0;
        end else if (r_busy) begin
            n_acc = w_sum[ACC_W-1:DW];
            n_lo  = {w_sum[DW-1:0], r_lo[QW-1:DW]};
            n_b   = r_b >> DW;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
        r_lo  <= n_lo;
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.prod_hi = {r_acc, r_lo[QW-1:met_pkg::FRAC_W]};
    assign o_rsp.frac_nz = |r_lo[met_pkg::FRAC_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/met_coord.sv -----
// Two-stage pipeline that maps a pixel index to a saturated Q4.60 coordinate.
`timescale 1ns / 1ps
`default_nettype none

module met_coord #(
    parameter int TILE_EDGE = met_pkg::TILE_EDGE_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    input  wire logic        [met_pkg::PIX_W-1:0] i_index,
    input  wire logic signed [met_pkg::Q_W-1:0]   i_center,
    input  wire logic        [met_pkg::ZOOM_W-1:0] i_zoom,
    output logic                                  o_valid,
    output logic signed      [met_pkg::Q_W-1:0]   o_coord
);

    localparam int QW     = met_pkg::Q_W;
    localparam int PW     = met_pkg::PIX_W;
    localparam int IDX_W  = $clog2(TILE_EDGE);
    localparam int D_W    = ((PW > IDX_W) ? PW : IDX_W) + 1;
    localparam int MAX_SH = 2 ** met_pkg::ZOOM_W - 1;
    localparam int T_W    = D_W + MAX_SH;
    localparam int DROP   = MAX_SH - met_pkg::FRAC_W;
    localparam int OFF_W  = T_W - DROP;
    localparam int SUM_W  = OFF_W + 1;
    localparam logic [D_W-1:0] HALF = D_W'(TILE_EDGE / 2);

    logic signed [D_W-1:0]             w_d;
    logic        [met_pkg::ZOOM_W-1:0] w_sh;
    logic signed [T_W-1:0]             w_t;
    logic signed [SUM_W-1:0]           w_sum;
    logic                              w_fits;

    logic                    r_v1, r_v2;
    logic signed [OFF_W-1:0] r_off;
    logic signed [QW-1:0]    r_center;
    logic signed [QW-1:0]    r_coord;

    // The offset is d * 2^(63 - zoom) shifted right by three, which floors it.
    assign w_d  = {{(D_W - PW){1'b0}}, i_index} - HALF;
    assign w_sh = met_pkg::ZOOM_W'(MAX_SH) - i_zoom;
    assign w_t  = T_W'(w_d) <<< w_sh;

    assign w_sum  = SUM_W'(r_off) + SUM_W'(r_center);
    assign w_fits = (w_sum[SUM_W-1:QW-1] == {(SUM_W - QW + 1){w_sum[SUM_W-1]}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_off    <= w_t[T_W-1:DROP];
        r_center <= i_center;
        if (w_fits) begin
            r_coord <= w_sum[QW-1:0];
        end else if (w_sum[SUM_W-1]) begin
            r_coord <= {1'b1, {(QW - 1){1'b0}}};
        end else begin
            r_coord <= {1'b0, {(QW - 1){1'b1}}};
        end
    end

    assign o_valid = r_v2;
    assign o_coord = r_coord;

endmodule

`default_nettype wire

// ----- rtl/mandelbrot_escape_time_unit.sv -----
// Top level of the Mandelbrot escape-time unit: controller, registers and datapath.
//
// Usage: a pixel item (pixel_col, pixel_row) enters on i_pixel and one result item
// (escape_count, no_escape) leaves on o_result for each of them, in order. The
// tile center and zoom are written through i_cfg while the unit is idle; writes
// are always taken, and an index beyond the three registers is ignored.
// Each pixel is worked on alone. Setup passes through the coordinate pipeline,
// and every iteration is paced by the single shared digit-serial multiplier:
// three products of four 16-bit digits, each with issue and completion cycles,
// plus the bound test and the update; an iteration that escapes skips the cross
// product and the update. The result sits in an output register. The next
// pixel is accepted while that result still waits; if the receiver stalls, the
// following result waits in the controller until the output register frees
// up, and no further pixel is taken.
// Synchronous reset clears the center and zoom to zero, empties the output
// register and returns the controller to idle.
`timescale 1ns / 1ps
`default_nettype none

module mandelbrot_escape_time_unit #(
    parameter int ITER_LIMIT = met_pkg::ITER_LIMIT_DEF,
    parameter int TILE_EDGE  = met_pkg::TILE_EDGE_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    met_chan_if.sink    i_pixel,
    met_chan_if.source  o_result,
    met_chan_if.sink    i_cfg
);

    localparam int QW     = met_pkg::Q_W;
    localparam int HW     = met_pkg::HI_W;
    localparam int CW     = met_pkg::CNT_W;
    localparam int STEP_W = $clog2(ITER_LIMIT + 1);
    localparam int UPD_W  = QW + 4;
    localparam logic [STEP_W-1:0] LIMIT = STEP_W'(ITER_LIMIT);
    localparam logic [HW:0]       FOUR_RAW = (HW + 1)'(1) << (QW - 2);
    localparam logic [31:0]       CNT_MAX = 32'(2 ** CW - 1);

    // Magnitude of a signed value; the most negative value maps to 2^63.
    function automatic logic [QW-1:0] mag(input logic signed [QW-1:0] v);
        return v[QW-1] ? QW'(-v) : QW'(v);
    endfunction

    // Clamp a wide exact sum to the signed 64-bit range.
    function automatic logic signed [QW-1:0] sat_q(input logic signed [UPD_W-1:0] v);
        logic fits;
        fits = (v[UPD_W-1:QW-1] == {(UPD_W - QW + 1){v[UPD_W-1]}});
        if (fits) begin
            return v[QW-1:0];
        end else if (v[UPD_W-1]) begin
            return {1'b1, {(QW - 1){1'b0}}};
        end else begin
            return {1'b0, {(QW - 1){1'b1}}};
        end
    endfunction

    // Configuration registers.
    logic signed [QW-1:0]                r_center_real;
    logic signed [QW-1:0]                r_center_imag;
    logic        [met_pkg::ZOOM_W-1:0]   r_zoom;

    // Controller and datapath registers.
    met_pkg::t_state      r_state, n_state;
    logic [STEP_W-1:0]    r_steps, n_steps;
    logic signed [QW-1:0] r_cr, n_cr;
    logic signed [QW-1:0] r_ci, n_ci;
    logic signed [QW-1:0] r_zr, n_zr;
    logic signed [QW-1:0] r_zi, n_zi;
    logic [HW-1:0]        r_sr, n_sr;
    logic [HW-1:0]        r_si, n_si;
    logic signed [QW-1:0] r_diff, n_diff;
    logic [QW:0]          r_cross, n_cross;
    logic                 r_zneg, n_zneg;
    met_pkg::t_result     r_res, n_res;
    logic                 r_out_valid, n_out_valid;
    met_pkg::t_result     r_out, n_out;

    logic                 w_pix_acc;
    logic                 w_out_acc;
    logic                 w_load;
    logic                 w_cre_valid;
    logic                 w_cim_valid;
    logic signed [QW-1:0] w_cre;
    logic signed [QW-1:0] w_cim;
    logic [HW:0]          w_sq_sum;
    logic                 w_escape;
    logic [31:0]          w_steps32;
    logic [CW-1:0]        w_count;
    logic signed [UPD_W-1:0] w_zr_sum;
    logic signed [UPD_W-1:0] w_zi_sum;
    logic signed [UPD_W-1:0] w_ci_x;
    logic signed [UPD_W-1:0] w_cross_x;

    met_pkg::t_mul_req w_mul_req;
    met_pkg::t_mul_rsp w_mul_rsp;

    assign i_cfg.ready    = 1'b1;
    assign i_pixel.ready  = (r_state == met_pkg::S_IDLE);
    assign w_pix_acc      = i_pixel.valid && i_pixel.ready;
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;
    assign w_out_acc      = r_out_valid && o_result.ready;
    assign w_load         = (r_state == met_pkg::S_DONE) && (!r_out_valid || o_result.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_real <= '0;
            r_center_imag <= '0;
            r_zoom        <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.data.reg_index)
                met_pkg::REG_CENTER_REAL: r_center_real <= i_cfg.data.write_data;
                met_pkg::REG_CENTER_IMAG: r_center_imag <= i_cfg.data.write_data;
                met_pkg::REG_ZOOM_LEVEL:
                    r_zoom <= i_cfg.data.write_data[met_pkg::ZOOM_W-1:0];
                default: ;
            endcase
        end
    end

    // Both coordinates are formed in parallel when a pixel is taken.
    met_coord #(.TILE_EDGE(TILE_EDGE)) u_coord_re (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_pix_acc),
        .i_index  (i_pixel.data.pixel_col),
        .i_center (r_center_real),
        .i_zoom   (r_zoom),
        .o_valid  (w_cre_valid),
        .o_coord  (w_cre)
    );

    met_coord #(.TILE_EDGE(TILE_EDGE)) u_coord_im (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_pix_acc),
        .i_index  (i_pixel.data.pixel_row),
        .i_center (r_center_imag),
        .i_zoom   (r_zoom),
        .o_valid  (w_cim_valid),
        .o_coord  (w_cim)
    );

    met_digit_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_rsp   (w_mul_rsp)
    );

    // Bound test on the truncated squares; sums of both cover each one alone.
    assign w_sq_sum = {1'b0, r_sr} + {1'b0, r_si};
    assign w_escape = (w_sq_sum > FOUR_RAW);

    assign w_steps32 = 32'(r_steps);
    assign w_count   = (w_steps32 > CNT_MAX) ? {CW{1'b1}} : w_steps32[CW-1:0];

    // Update: re' = cr + (re^2 - im^2), im' = ci + 2 * floor(re * im).
    assign w_zr_sum  = UPD_W'(r_cr) + UPD_W'(r_diff);
    assign w_ci_x    = UPD_W'(r_ci);
    assign w_cross_x = UPD_W'({r_cross, 1'b0});
    assign w_zi_sum  = r_zneg ? (w_ci_x - w_cross_x) : (w_ci_x + w_cross_x);

    always_comb begin
        n_state   = r_state;
        n_steps   = r_steps;
        n_cr      = r_cr;
        n_ci      = r_ci;
        n_zr      = r_zr;
        n_zi      = r_zi;
        n_sr      = r_sr;
        n_si      = r_si;
        n_diff    = r_diff;
        n_cross   = r_cross;
        n_zneg    = r_zneg;
        n_res     = r_res;
        w_mul_req = '{start: 1'b0, op_a: mag(r_zr), op_b: mag(r_zr)};
        case (r_state)
            met_pkg::S_IDLE: begin
                if (w_pix_acc) begin
                    n_state = met_pkg::S_COORD;
                end
            end
            met_pkg::S_COORD: begin
                if (w_cre_valid && w_cim_valid) begin
                    n_cr    = w_cre;
                    n_ci    = w_cim;
                    n_zr    = '0;
                    n_zi    = '0;
                    n_steps = '0;
                    n_state = met_pkg::S_ITER;
                end
            end
            met_pkg::S_ITER: begin
                if (r_steps == LIMIT) begin
                    n_res   = '{escape_count: '0, no_escape: 1'b1};
                    n_state = met_pkg::S_DONE;
                end else begin
                    w_mul_req.start = 1'b1;
                    n_state         = met_pkg::S_SQR_R;
                end
            end
            met_pkg::S_SQR_R: begin
                w_mul_req.op_a = mag(r_zi);
                w_mul_req.op_b = mag(r_zi);
                if (w_mul_rsp.done) begin
                    n_sr            = w_mul_rsp.prod_hi;
                    w_mul_req.start = 1'b1;
                    n_state         = met_pkg::S_SQR_I;
                end
            end
            met_pkg::S_SQR_I: begin
                if (w_mul_rsp.done) begin
                    n_si    = w_mul_rsp.prod_hi;
                    n_state = met_pkg::S_TEST;
                end
            end
            met_pkg::S_TEST: begin
                w_mul_req.op_b = mag(r_zi);
                if (w_escape) begin
                    n_res   = '{escape_count: w_count, no_escape: 1'b0};
                    n_state = met_pkg::S_DONE;
                end else begin
                    // Both squares are at most four here, so 63 bits hold them.
                    n_diff = QW'({1'b0, r_sr[QW-2:0]}) - QW'({1'b0, r_si[QW-2:0]});
                    n_zneg = r_zr[QW-1] ^ r_zi[QW-1];
                    w_mul_req.start = 1'b1;
                    n_state         = met_pkg::S_CROSS;
                end
            end
            met_pkg::S_CROSS: begin
                if (w_mul_rsp.done) begin
                    // A negative cross product rounds its magnitude up, i.e. floors.
                    n_cross = {1'b0, w_mul_rsp.prod_hi[QW-1:0]}
                            + (QW + 1)'(r_zneg && w_mul_rsp.frac_nz);
                    n_state = met_pkg::S_UPDATE;
                end
            end
            met_pkg::S_UPDATE: begin
                n_zr    = sat_q(w_zr_sum);
                n_zi    = sat_q(w_zi_sum);
                n_steps = r_steps + 1'b1;
                n_state = met_pkg::S_ITER;
            end
            met_pkg::S_DONE: begin
                if (w_load) begin
                    n_state = met_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = met_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (w_out_acc) begin
            n_out_valid = 1'b0;
        end
        if (w_load) begin
            n_out       = r_res;
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= met_pkg::S_IDLE;
            r_steps     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_steps     <= n_steps;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cr    <= n_cr;
        r_ci    <= n_ci;
        r_zr    <= n_zr;
        r_zi    <= n_zi;
        r_sr    <= n_sr;
        r_si    <= n_si;
        r_diff  <= n_diff;
        r_cross <= n_cross;
        r_zneg  <= n_zneg;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    // A product may only complete while the controller waits for one.
    a_mul_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_rsp.done |-> (r_state == met_pkg::S_SQR_R || r_state == met_pkg::S_SQR_I
                            || r_state == met_pkg::S_CROSS))
        else $error("multiplier finished outside a wait state");

    // The iteration counter never passes the limit.
    a_steps_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_steps <= LIMIT)
        else $error("step counter exceeded the iteration limit");

    // An update only follows a passed bound test.
    a_update_in_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == met_pkg::S_UPDATE) |-> !w_escape)
        else $error("update of z after the bound test failed");

    // A finished result lands in the output register once it is free.
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_out_valid && r_state == met_pkg::S_IDLE))
        else $error("finished result was not loaded");

    // A pixel that never escaped reports a zero count.
    a_no_escape_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.no_escape) |-> (r_out.escape_count == '0))
        else $error("no-escape result carries a count");

endmodule

`default_nettype wire

// ----- verif/tb_mandelbrot_escape_time_unit.sv -----
// Self-checking testbench for the Mandelbrot escape-time unit with a built-in escape predictor.
`timescale 1ns / 1ps

module tb_mandelbrot_escape_time_unit;

    import met_pkg::*;

    // The unit runs with its default sizes; the predictor uses the same values.
    localparam int ITER_LIMIT = ITER_LIMIT_DEF;
    localparam int TILE_EDGE  = TILE_EDGE_DEF;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 5;

    // Index that maps to no register; writes to it must leave the tile untouched.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    // Random stimulus is organized in phases, each with its own tile setting.
    localparam int RANDOM_PHASES   = 14;
    localparam int ITEMS_PER_PHASE = 100;

    // After this many results the receiver stops taking items for a long stretch,
    // so that the output register and the controller both fill and i_pixel stalls.
    localparam int HOLD_AFTER  = 60;
    localparam int HOLD_CYCLES = 12000;

    // Drain time, sized for a pixel that never escapes and so runs every iteration.
    localparam int DRAIN_CYCLES = 18 * ITER_LIMIT + 32;

    // Slowest correct run: every item at the iteration limit with the longest
    // gaps and stalls, plus the hold-off, then taken several times over.
    localparam int TIMEOUT_NS = 400_000_000;

    localparam logic signed [127:0] Q_POS_MAX    = {64'd0, 1'b0, {63{1'b1}}};
    localparam logic signed [127:0] Q_NEG_MAX    = {{65{1'b1}}, 63'd0};
    localparam logic signed [127:0] ESCAPE_BOUND = 128'h4000_0000_0000_0000;

    typedef enum logic {
        ROW_WRITE,
        ROW_PIXEL
    } t_row_kind;

    // One line of the directed table: either a register write or a pixel item.
    // Where typed is set, result holds the expected outcome written out by hand.
    typedef struct {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] reg_index;
        logic [Q_W-1:0]       write_data;
        t_pixel               pixel;
        bit                   typed;
        t_result              result;
    } t_directed_row;

    localparam t_result NEVER_ESCAPES = '{8'd0, 1'b1};
    localparam t_result ONE_STEP      = '{8'd1, 1'b0};
    localparam t_result NO_RESULT     = '{8'd0, 1'b0};

    localparam int NUM_DIRECTED = 30;

    // Directed part. It starts from the reset setting (center 0, zoom 0), where one
    // pixel is one whole unit, so most outcomes are obvious: the origin never
    // escapes, far pixels leave after one step, c = 1 leaves after three, and
    // c = -2 sits exactly on the |z| = 2 bound forever. It then covers an ignored
    // write to the unmapped index, the finest listed zoom, the zooms below one
    // LSB (offset rounded toward minus infinity), saturated centers, and a few
    // points around the main cardioid at a moderate zoom.
    t_directed_row directed_rows [0:NUM_DIRECTED-1] = '{
        '{ROW_PIXEL, REG_UNMAPPED, 64'd0, '{9'd256, 9'd256}, 1'b1, NEVER_ESCAPES},
        '{ROW_PIXEL, REG_UNMAPPED, 64'd0, '{9'd0, 9'd0}, 1'b1, ONE_STEP},
        '{ROW_PIXEL, REG_UNMAPPED, 64'd0, '{9'd511, 9'd511}, 1'b1, ONE_STEP},
        '{ROW_PIXEL, REG_UNMAPPED, 64'd0, '{9'd257, 9'd256}, 1'b1, '{8'd3, 1'b0}},
        '{ROW_PIXEL, REG_UNMAPPED, 64'd0, '{9'd254, 9'd256}, 1'b1, NEVER_ESCAPES},
        '{ROW_PIXEL, REG_UNMAPPED, 64'd0, '{9'd256, 9'd511}, 1'b1, ONE_STEP},
        '{ROW_PIXEL, REG_UNMAPPED, 64'd0, '{9'd511, 9'd0}, 1'b1, ONE_STEP},
        '{ROW_WRITE, REG_UNMAPPED, 64'h7FFF_FFFF_FFFF_FFFF, '0, 1'b0, NO_RESULT},
        '{ROW_PIXEL, REG_UNMAPPED, 64'd0, '{9'd256, 9'd256}, 1'b1, NEVER_ESCAPES},
        '{ROW_WRITE, REG_ZOOM_LEVEL, 64'hFFFF_FFFF_FFFF_FFFC, '0, 1'b0, NO_RESULT},
        '{ROW_PIXEL, REG_UNMAPPED, 64'd0, '{9'd0, 9'd511}, 1'b1, NEVER_ESCAPES},
        '{ROW_WRITE, REG_ZOOM_LEVEL, 64'h0000_0000_0000_003F, '0, 1'b0, NO_RESULT},
        '{ROW_PIXEL, REG_UNMAPPED, 64'd0, '{9'd0, 9'd0}, 1'b0, NO_RESULT},
        '{ROW_PIXEL, REG_UNMAPPED, 64'd0, '{9'd511, 9'd1}, 1'b0, NO_RESULT},
        '{ROW_WRITE, REG_CENTER_REAL, 64'h7FFF_FFFF_FFFF_FFFF, '0, 1'b0, NO_RESULT},
        '{ROW_WRITE, REG_ZOOM_LEVEL, 64'd0, '0, 1'b0, NO_RESULT},
        '{ROW_PIXEL, REG_UNMAPPED, 64'd0, '{9'd511, 9'd256}, 1'b0, NO_RESULT},
        '{ROW_PIXEL, REG_UNMAPPED, 64'd0, '{9'd0, 9'd256}, 1'b0, NO_RESULT},
        '{ROW_WRITE, REG_CENTER_REAL, 64'h8000_0000_0000_0000, '0, 1'b0, NO_RESULT},
        '{ROW_WRITE, REG_CENTER_IMAG, 64'h8000_0000_0000_0000, '0, 1'b0, NO_RESULT},
        '{ROW_PIXEL, REG_UNMAPPED, 64'd0, '{9'd0, 9'd0}, 1'b0, NO_RESULT},
        '{ROW_PIXEL, REG_UNMAPPED, 64'd0, '{9'd511, 9'd511}, 1'b0, NO_RESULT},
        '{ROW_WRITE, REG_CENTER_IMAG, 64'h7FFF_FFFF_FFFF_FFFF, '0, 1'b0, NO_RESULT},
        '{ROW_PIXEL, REG_UNMAPPED, 64'd0, '{9'd256, 9'd511}, 1'b0, NO_RESULT},
        '{ROW_WRITE, REG_CENTER_REAL, 64'd0, '0, 1'b0, NO_RESULT},
        '{ROW_WRITE, REG_CENTER_IMAG, 64'd0, '0, 1'b0, NO_RESULT},
        '{ROW_WRITE, REG_ZOOM_LEVEL, 64'd8, '0, 1'b0, NO_RESULT},
        '{ROW_PIXEL, REG_UNMAPPED, 64'd0, '{9'd128, 9'd256}, 1'b0, NO_RESULT},
        '{ROW_PIXEL, REG_UNMAPPED, 64'd0, '{9'd320, 9'd256}, 1'b0, NO_RESULT},
        '{ROW_PIXEL, REG_UNMAPPED, 64'd0, '{9'd290, 9'd410}, 1'b0, NO_RESULT}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    met_chan_if #(.T(t_pixel))  pixel_ch ();
    met_chan_if #(.T(t_result)) result_ch ();
    met_chan_if #(.T(t_cfg))    cfg_ch ();

    // Copy of the tile setting, updated at each accepted register write.
    logic signed [Q_W-1:0] tile_center_re = '0;
    logic signed [Q_W-1:0] tile_center_im = '0;
    logic [ZOOM_W-1:0]     tile_zoom      = '0;

    // Outcomes predicted for accepted pixels, oldest first.
    t_result pending_escapes [$];

    int  check_failures = 0;
    bit  steady_sender  = 1'b0;

    mandelbrot_escape_time_unit #(
        .ITER_LIMIT(ITER_LIMIT),
        .TILE_EDGE (TILE_EDGE)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pixel (pixel_ch),
        .o_result(result_ch),
        .i_cfg   (cfg_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Clamps an exact value to the signed Q4.60 range.
    function automatic logic signed [Q_W-1:0] clamp_q60(logic signed [127:0] v);
        if (v > Q_POS_MAX) begin
            return Q_POS_MAX[Q_W-1:0];
        end
        if (v < Q_NEG_MAX) begin
            return Q_NEG_MAX[Q_W-1:0];
        end
        return v[Q_W-1:0];
    endfunction

    // One coordinate of c: center plus the pixel offset from the tile middle,
    // scaled by 2^-zoom. Zooms past 60 shift right and so round toward minus
    // infinity, which an arithmetic shift of the exact offset does directly.
    function automatic logic signed [Q_W-1:0] pixel_coord(logic signed [Q_W-1:0] center,
                                                         logic [PIX_W-1:0] index);
        logic signed [127:0] offset;
        offset = $signed({119'd0, index}) - (TILE_EDGE / 2);
        if (tile_zoom <= FRAC_W) begin
            offset = offset <<< (FRAC_W - tile_zoom);
        end else begin
            offset = offset >>> (tile_zoom - FRAC_W);
        end
        return clamp_q60(offset + center);
    endfunction

    // Iterates z = z*z + c from zero. Products are exact and then floored to
    // Q4.60; a signed floor of the cross term is what the unit computes from
    // magnitudes (round down when positive, round up the magnitude when negative).
    function automatic t_result predict_escape(t_pixel px);
        logic signed [127:0] c_re;
        logic signed [127:0] c_im;
        logic signed [127:0] z_re;
        logic signed [127:0] z_im;
        logic signed [127:0] sq_re;
        logic signed [127:0] sq_im;
        logic signed [127:0] cross_term;
        int                  steps;
        t_result             outcome;
        c_re  = pixel_coord(tile_center_re, px.pixel_col);
        c_im  = pixel_coord(tile_center_im, px.pixel_row);
        z_re  = '0;
        z_im  = '0;
        steps = 0;
        while (steps < ITER_LIMIT) begin
            sq_re = (z_re * z_re) >>> FRAC_W;
            sq_im = (z_im * z_im) >>> FRAC_W;
            if (sq_re + sq_im > ESCAPE_BOUND) begin
                break;
            end
            cross_term = (z_re * z_im) >>> FRAC_W;
            z_re       = clamp_q60(c_re + sq_re - sq_im);
            z_im       = clamp_q60(c_im + (cross_term <<< 1));
            steps++;
        end
        outcome.no_escape    = (steps >= ITER_LIMIT);
        outcome.escape_count = outcome.no_escape ? '0 :
                               (steps > 255) ? 8'd255 : CNT_W'(steps);
        return outcome;
    endfunction

    // Pixel index for random items: mostly uniform, sometimes a tile border or
    // the two middle indexes.
    function automatic logic [PIX_W-1:0] pick_pixel_index();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return PIX_W'(TILE_EDGE / 2 - $urandom_range(0, 1));
            default: return PIX_W'($urandom_range(0, TILE_EDGE - 1));
        endcase
    endfunction

    // Waits until every predicted outcome has come back. Each pixel yields
    // exactly one result, so an empty store means the unit is idle.
    task automatic wait_idle();
        while (pending_escapes.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Writes one register and mirrors it in the predictor's copy of the tile.
    task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [Q_W-1:0] value);
        cfg_ch.valid           = 1'b1;
        cfg_ch.data.reg_index  = index;
        cfg_ch.data.write_data = value;
        do begin
            @(posedge i_clk);
        end while (!cfg_ch.ready);
        case (index)
            REG_CENTER_REAL: tile_center_re = value;
            REG_CENTER_IMAG: tile_center_im = value;
            REG_ZOOM_LEVEL:  tile_zoom      = value[ZOOM_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Offers one pixel item after a random gap, or none when steady_sender is set,
    // and records its expected outcome at the edge where it is accepted.
    task automatic send_pixel(t_pixel px, bit typed, t_result typed_result);
        int gap;
        gap = steady_sender ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            pixel_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pixel_ch.valid = 1'b1;
        pixel_ch.data  = px;
        do begin
            @(posedge i_clk);
        end while (!pixel_ch.ready);
        pending_escapes.push_back(typed ? typed_result : predict_escape(px));
        @(negedge i_clk);
        pixel_ch.valid = 1'b0;
    endtask

    // Stimulus: reset, the directed table, then random phases. Each phase waits
    // for the unit to go idle, picks a new tile and sends a burst of pixels.
    initial begin : stimulus
        t_pixel         px;
        int             phase_kind;
        logic [Q_W-1:0] low_bits;
        logic [Q_W-1:0] center_re_pick;
        logic [Q_W-1:0] center_im_pick;
        logic [Q_W-1:0] zoom_word;

        i_rst_n        = 1'b0;
        pixel_ch.valid = 1'b0;
        pixel_ch.data  = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.data    = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WRITE) begin
                wait_idle();
                write_register(directed_rows[i].reg_index, directed_rows[i].write_data);
            end else begin
                send_pixel(directed_rows[i].pixel, directed_rows[i].typed,
                           directed_rows[i].result);
            end
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_idle();
            low_bits   = {$urandom, $urandom};
            zoom_word  = {$urandom, $urandom};
            phase_kind = $urandom_range(0, 9);
            if (phase_kind < 5) begin
                // Close to the set: real part in [-2, 0.5], imaginary in [-1.25, 1.25],
                // with a tile a few units wide down to a small fraction of one.
                center_re_pick = ((longint'($urandom_range(0, 2560)) - 2048) <<< 50)
                                 + longint'(low_bits >> 14);
                center_im_pick = ((longint'($urandom_range(0, 2560)) - 1280) <<< 50)
                                 + longint'(low_bits >> 15);
                zoom_word[ZOOM_W-1:0] = ZOOM_W'($urandom_range(7, 12));
            end else if (phase_kind < 8) begin
                // Wide tiles, where most pixels leave after a handful of steps.
                center_re_pick = ((longint'($urandom_range(0, 8192)) - 4096) <<< 50)
                                 + longint'(low_bits >> 14);
                center_im_pick = ((longint'($urandom_range(0, 8192)) - 4096) <<< 50)
                                 + longint'(low_bits >> 15);
                zoom_word[ZOOM_W-1:0] = ZOOM_W'($urandom_range(0, 6));
            end else begin
                // Anything the registers hold, including full-scale centers.
                center_re_pick = {$urandom, $urandom};
                center_im_pick = {$urandom, $urandom};
                case ($urandom_range(0, 2))
                    0: center_re_pick = Q_POS_MAX[Q_W-1:0];
                    1: center_im_pick = Q_NEG_MAX[Q_W-1:0];
                    default: ;
                endcase
                zoom_word[ZOOM_W-1:0] = ZOOM_W'($urandom_range(0, 63));
            end
            write_register(REG_CENTER_REAL, center_re_pick);
            write_register(REG_CENTER_IMAG, center_im_pick);
            write_register(REG_ZOOM_LEVEL, zoom_word);
            if ($urandom_range(0, 3) == 0) begin
                write_register(REG_UNMAPPED, {$urandom, $urandom});
            end

            // Some phases send back to back to keep the input side busy.
            steady_sender = ($urandom_range(0, 3) == 0);
            repeat (ITEMS_PER_PHASE) begin
                px.pixel_col = pick_pixel_index();
                px.pixel_row = pick_pixel_index();
                send_pixel(px, 1'b0, NO_RESULT);
            end
            steady_sender = 1'b0;
        end

        // Let any stray result show up before the verdict.
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (check_failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Result receiver: stalls at random (with quiet stretches), holds off once
    // for a long time, and compares each result with the oldest prediction.
    initial begin : result_sink
        int      stall;
        int      taken;
        bit      quiet;
        t_result got;
        t_result want;

        result_ch.ready = 1'b0;
        taken           = 0;
        quiet           = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (taken % 64 == 0) begin
                quiet = ($urandom_range(0, 3) == 0);
            end
            if (taken == HOLD_AFTER) begin
                stall = HOLD_CYCLES;
            end else begin
                stall = quiet ? 0 : $urandom_range(0, 3);
            end
            if (stall > 0) begin
                result_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            result_ch.ready = 1'b1;
            do begin
                @(posedge i_clk);
            end while (!result_ch.valid);
            got = result_ch.data;
            if (pending_escapes.size() == 0) begin
                if (check_failures < 10) begin
                    $display("result %0d arrived with no pixel outstanding: count %0d flag %0b",
                             taken, got.escape_count, got.no_escape);
                end
                check_failures++;
            end else begin
                want = pending_escapes.pop_front();
                if (got.escape_count !== want.escape_count ||
                    got.no_escape !== want.no_escape) begin
                    if (check_failures < 10) begin
                        $display("result %0d: expected count %0d flag %0b, got count %0d flag %0b",
                                 taken, want.escape_count, want.no_escape,
                                 got.escape_count, got.no_escape);
                    end
                    check_failures++;
                end
            end
            taken++;
            @(negedge i_clk);
        end
    end

    // Hang guard.
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/met_pkg.sv
rtl/met_chan_if.sv
rtl/met_digit_mul.sv
rtl/met_coord.sv
rtl/mandelbrot_escape_time_unit.sv
verif/tb_mandelbrot_escape_time_unit.sv
